### rtl/twodo_pkg.sv
// Package for the three tracking wheel odometry block: payload structs, serial
// arithmetic unit interface, fixed point constants and helper functions.
// No dependencies.
package twodo_pkg;

  localparam int STEPS = 24;
  localparam int CW    = 36;

  typedef logic signed [CW-1:0] cw_t;

  localparam logic [63:0]        LIM_U     = 64'h4000_0000_0000_0000;
  localparam logic signed [63:0] PI_Q30    = 64'sd3373259426;
  localparam logic signed [63:0] TWO_PI_Q30 = 64'sd6746518852;
  localparam cw_t                C_PI      = 36'sd3373259426;
  localparam cw_t                C_TWO_PI  = 36'sd6746518852;
  localparam cw_t                C_HALF_PI = 36'sd1686629713;
  localparam cw_t                C_GAIN    = 36'sd652032874;
  localparam logic signed [63:0] ONE_Q30   = 64'sd1073741824;
  localparam logic signed [63:0] DEN_RAD   = 64'sd754974720;
  localparam logic signed [63:0] DEN_TICK  = 64'sd36000;
  localparam logic signed [63:0] MAX48     = 64'sd140737488355327;
  localparam logic signed [63:0] MIN48     = -64'sd140737488355328;

  localparam logic [29:0] ATAN [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef enum logic [2:0] {
    REG_CIRC, REG_LOFF, REG_ROFF, REG_BOFF, REG_SX, REG_SY, REG_SH
  } reg_idx_t;

  typedef enum logic [1:0] {OP_MUL_RAW, OP_MUL30, OP_DIV} alu_op_t;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic signed [31:0] back_position;
  } in_t;

  typedef struct packed {
    logic signed [47:0] x_position;
    logic signed [47:0] y_position;
    logic signed [47:0] heading_radians;
    logic signed [47:0] heading_degrees;
  } out_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [4:0]         e;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
    logic [63:0]        q;
    logic [63:0]        rem;
  } alu_rsp_t;

  function automatic logic [63:0] umag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] from_mag(logic [63:0] q, logic neg);
    logic [63:0] c;
    c = (q > LIM_U) ? LIM_U : q;
    return neg ? -$signed(c) : $signed(c);
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [63:0] v);
    if (v > MAX48) return MAX48[47:0];
    if (v < MIN48) return MIN48[47:0];
    return v[47:0];
  endfunction

endpackage

### rtl/three_wheel_odometry_top.sv
// Three tracking wheel arc odometry: sequencer, pose state, CORDIC, config port.
// Depends on twodo_pkg and twodo_alu.
//
//  channel | ports                               | role
//  in      | in_valid, in_stall, in_data         | wheel positions, one item per sample
//  out     | out_valid, out_stall, out_data      | pose after each sample
//  cfg     | psel, penable, pwrite, paddr, ...   | geometry and start pose registers
//
// An item takes more work when the heading changes, and the first item after
// a start_heading write also converts the start heading; each multiply or
// divide runs as 64 bit-serial steps in the shared unit (a saturating divide
// skips them) and the CORDIC runs once for a straight move, twice for a turn.
// Synchronous active-low reset; no clearing pass.  in_stall is high while an
// item is in work; the finished pose waits in the output register.
module three_wheel_odometry_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  twodo_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output twodo_pkg::out_t  out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_HL_M, ST_HL_D, ST_DL_M, ST_DL_D, ST_DR_M, ST_DR_D, ST_DS_M,
    ST_DS_D, ST_A_D, ST_I_MOD, ST_C_RNG1, ST_C_RNG2, ST_C_IT, ST_C_END,
    ST_K_I2, ST_K_I4, ST_K_Q1, ST_K_Q2, ST_K_DIV, ST_H1, ST_H2, ST_H3, ST_H4,
    ST_P_MOD, ST_Y1, ST_Y2, ST_X1, ST_X2, ST_DEG_M, ST_DEG_D, ST_PUSH
  } state_t;

  state_t state_r;
  logic   issued_r, hpend_r, out_valid_r;
  twodo_pkg::out_t out_data_r;

  logic [23:0]        circ_r, loff_r, roff_r, boff_r;
  logic [31:0]        sx_r, sy_r;
  logic [25:0]        sh_r;
  logic signed [31:0] cur_l_r, cur_r_r, cur_b_r, last_l_r, last_r_r, last_b_r;
  logic signed [47:0] pose_x_r, pose_y_r, pose_h_r, a_r, deg_r;
  logic signed [63:0] acc_r, dl_r, dr_r, ds_r, k_r, h_r, h2_r, i2_r;
  twodo_pkg::cw_t     cx_r, cy_r, cz_r, si_r, sp_r, cp_r;
  logic               flip_r, csel_r;
  logic [4:0]         cnt_r;

  twodo_pkg::alu_req_t alu_req;
  twodo_pkg::alu_rsp_t alu_rsp;

  twodo_alu u_alu (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));

  logic signed [32:0] d_l, d_r, d_b;
  logic [24:0]        ssum;
  logic signed [63:0] i30, pz, si64, sp64, cp64, h2x;
  logic signed [47:0] a_new;
  logic               i_small, uses, cfg_wr;
  twodo_pkg::cw_t     sx_sh, sy_sh, at;
  twodo_pkg::reg_idx_t ridx;

  function automatic twodo_pkg::cw_t mod_z(logic [63:0] rem, logic neg);
    twodo_pkg::cw_t m;
    m = twodo_pkg::cw_t'(rem[twodo_pkg::CW-1:0]);
    return neg ? -m : m;
  endfunction

  always_comb begin
    d_l   = {cur_l_r[31], cur_l_r} - {last_l_r[31], last_l_r};
    d_r   = {cur_r_r[31], cur_r_r} - {last_r_r[31], last_r_r};
    d_b   = {cur_b_r[31], cur_b_r} - {last_b_r[31], last_b_r};
    ssum  = {1'b0, loff_r} + {1'b0, roff_r};
    i30   = {{11{a_r[47]}}, a_r, 5'b0};
    pz    = i30 + {{10{pose_h_r[47]}}, pose_h_r, 6'b0};
    si64  = 64'(si_r);
    sp64  = 64'(sp_r);
    cp64  = 64'(cp_r);
    h2x   = alu_rsp.res <<< 1;
    a_new = twodo_pkg::sat48(alu_rsp.res);
    i_small = twodo_pkg::umag(i30) < 64'h400_0000;
    sx_sh = cx_r >>> cnt_r;
    sy_sh = cy_r >>> cnt_r;
    at    = {6'b0, twodo_pkg::ATAN[cnt_r]};
    ridx  = twodo_pkg::reg_idx_t'(paddr[4:2]);
    cfg_wr = psel && penable && pwrite;
  end

  always_comb begin
    alu_req.op = twodo_pkg::OP_MUL30;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.e  = '0;
    uses       = 1'b1;
    unique case (state_r)
      ST_HL_M: begin
        alu_req.op = twodo_pkg::OP_MUL_RAW;
        alu_req.a  = {{38{sh_r[25]}}, sh_r};
        alu_req.b  = twodo_pkg::PI_Q30;
      end
      ST_HL_D: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = acc_r;
        alu_req.b  = twodo_pkg::DEN_RAD;
      end
      ST_DL_M, ST_DR_M, ST_DS_M: begin
        alu_req.op = twodo_pkg::OP_MUL_RAW;
        alu_req.a  = (state_r == ST_DL_M) ? 64'(d_l) :
                     (state_r == ST_DR_M) ? 64'(d_r) : 64'(d_b);
        alu_req.b  = {40'b0, circ_r};
      end
      ST_DL_D, ST_DR_D, ST_DS_D: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = acc_r;
        alu_req.b  = twodo_pkg::DEN_TICK;
      end
      ST_A_D: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = dl_r - dr_r;
        alu_req.b  = {39'b0, ssum};
        alu_req.e  = 5'd24;
      end
      ST_I_MOD: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = i30;
        alu_req.b  = twodo_pkg::TWO_PI_Q30;
      end
      ST_P_MOD: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = pz;
        alu_req.b  = twodo_pkg::TWO_PI_Q30;
      end
      ST_K_I2: begin
        alu_req.a = i30;
        alu_req.b = i30;
      end
      ST_K_I4: begin
        alu_req.a = i2_r;
        alu_req.b = i2_r;
      end
      ST_K_Q1: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = i2_r + 64'sd3;
        alu_req.b  = 64'sd6;
      end
      ST_K_Q2: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = acc_r + 64'sd60;
        alu_req.b  = 64'sd120;
      end
      ST_K_DIV: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = si64;
        alu_req.b  = i30;
        alu_req.e  = 5'd30;
      end
      ST_H1: begin
        alu_req.a = dr_r;
        alu_req.b = k_r;
      end
      ST_H2: begin
        alu_req.a = {40'b0, roff_r};
        alu_req.b = si64;
      end
      ST_H3: begin
        alu_req.a = ds_r;
        alu_req.b = k_r;
      end
      ST_H4: begin
        alu_req.a = {40'b0, boff_r};
        alu_req.b = si64;
      end
      ST_Y1: begin
        alu_req.a = h_r;
        alu_req.b = cp64;
      end
      ST_Y2: begin
        alu_req.a = h2_r;
        alu_req.b = sp64;
      end
      ST_X1: begin
        alu_req.a = h_r;
        alu_req.b = sp64;
      end
      ST_X2: begin
        alu_req.a = h2_r;
        alu_req.b = cp64;
      end
      ST_DEG_M: begin
        alu_req.op = twodo_pkg::OP_MUL_RAW;
        alu_req.a  = 64'(pose_h_r);
        alu_req.b  = 64'sd180;
      end
      ST_DEG_D: begin
        alu_req.op = twodo_pkg::OP_DIV;
        alu_req.a  = acc_r;
        alu_req.b  = twodo_pkg::PI_Q30;
        alu_req.e  = 5'd22;
      end
      default: uses = 1'b0;
    endcase
    alu_req.start = uses && !issued_r;
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      twodo_pkg::REG_CIRC: prdata = {8'b0, circ_r};
      twodo_pkg::REG_LOFF: prdata = {8'b0, loff_r};
      twodo_pkg::REG_ROFF: prdata = {8'b0, roff_r};
      twodo_pkg::REG_BOFF: prdata = {8'b0, boff_r};
      twodo_pkg::REG_SX:   prdata = sx_r;
      twodo_pkg::REG_SY:   prdata = sy_r;
      twodo_pkg::REG_SH:   prdata = {{6{sh_r[25]}}, sh_r};
      default:             prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      hpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
      circ_r      <= 24'd565248;
      loff_r      <= 24'd458752;
      roff_r      <= 24'd458752;
      boff_r      <= 24'd327680;
      sx_r        <= '0;
      sy_r        <= '0;
      sh_r        <= '0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      last_b_r    <= '0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
    end else begin
      if (alu_req.start) issued_r <= 1'b1;
      if (alu_rsp.done)  issued_r <= 1'b0;
      if (out_valid_r && !out_stall && state_r != ST_PUSH) out_valid_r <= 1'b0;

      if (cfg_wr) begin
        unique case (ridx)
          twodo_pkg::REG_CIRC: circ_r <= pwdata[23:0];
          twodo_pkg::REG_LOFF: loff_r <= pwdata[23:0];
          twodo_pkg::REG_ROFF: roff_r <= pwdata[23:0];
          twodo_pkg::REG_BOFF: boff_r <= pwdata[23:0];
          twodo_pkg::REG_SX: begin
            sx_r     <= pwdata;
            pose_x_r <= {{16{pwdata[31]}}, pwdata};
          end
          twodo_pkg::REG_SY: begin
            sy_r     <= pwdata;
            pose_y_r <= {{16{pwdata[31]}}, pwdata};
          end
          twodo_pkg::REG_SH: begin
            sh_r    <= pwdata[25:0];
            hpend_r <= 1'b1;
          end
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cur_l_r <= in_data.left_position;
            cur_r_r <= in_data.right_position;
            cur_b_r <= in_data.back_position;
            state_r <= hpend_r ? ST_HL_M : ST_DL_M;
          end
        end
        ST_HL_M: if (alu_rsp.done) begin
          acc_r   <= alu_rsp.res;
          state_r <= ST_HL_D;
        end
        ST_HL_D: if (alu_rsp.done) begin
          pose_h_r <= a_new;
          hpend_r  <= 1'b0;
          state_r  <= ST_DL_M;
        end
        ST_DL_M: if (alu_rsp.done) begin
          acc_r   <= alu_rsp.res;
          state_r <= ST_DL_D;
        end
        ST_DL_D: if (alu_rsp.done) begin
          dl_r    <= alu_rsp.res;
          state_r <= ST_DR_M;
        end
        ST_DR_M: if (alu_rsp.done) begin
          acc_r   <= alu_rsp.res;
          state_r <= ST_DR_D;
        end
        ST_DR_D: if (alu_rsp.done) begin
          dr_r    <= alu_rsp.res;
          state_r <= ST_DS_M;
        end
        ST_DS_M: if (alu_rsp.done) begin
          acc_r   <= alu_rsp.res;
          state_r <= ST_DS_D;
        end
        ST_DS_D: if (alu_rsp.done) begin
          ds_r <= alu_rsp.res;
          if (ssum == 25'd0) begin
            a_r     <= '0;
            h_r     <= dr_r;
            h2_r    <= alu_rsp.res;
            state_r <= ST_P_MOD;
          end else begin
            state_r <= ST_A_D;
          end
        end
        ST_A_D: if (alu_rsp.done) begin
          a_r <= a_new;
          if (a_new == 48'sd0) begin
            h_r     <= dr_r;
            h2_r    <= ds_r;
            state_r <= ST_P_MOD;
          end else begin
            state_r <= ST_I_MOD;
          end
        end
        ST_I_MOD: if (alu_rsp.done) begin
          cz_r    <= mod_z(alu_rsp.rem, a_r[47]);
          csel_r  <= 1'b0;
          state_r <= ST_C_RNG1;
        end
        ST_P_MOD: if (alu_rsp.done) begin
          cz_r    <= mod_z(alu_rsp.rem, pz[63]);
          csel_r  <= 1'b1;
          state_r <= ST_C_RNG1;
        end
        ST_C_RNG1: begin
          if (cz_r > twodo_pkg::C_PI) cz_r <= cz_r - twodo_pkg::C_TWO_PI;
          else if (cz_r < -twodo_pkg::C_PI) cz_r <= cz_r + twodo_pkg::C_TWO_PI;
          state_r <= ST_C_RNG2;
        end
        ST_C_RNG2: begin
          if (cz_r > twodo_pkg::C_HALF_PI) begin
            cz_r   <= cz_r - twodo_pkg::C_PI;
            flip_r <= 1'b1;
          end else if (cz_r < -twodo_pkg::C_HALF_PI) begin
            cz_r   <= cz_r + twodo_pkg::C_PI;
            flip_r <= 1'b1;
          end else begin
            flip_r <= 1'b0;
          end
          cx_r    <= twodo_pkg::C_GAIN;
          cy_r    <= '0;
          cnt_r   <= '0;
          state_r <= ST_C_IT;
        end
        ST_C_IT: begin
          if (!cz_r[twodo_pkg::CW-1]) begin
            cx_r <= cx_r - sy_sh;
            cy_r <= cy_r + sx_sh;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + sy_sh;
            cy_r <= cy_r - sx_sh;
            cz_r <= cz_r + at;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(twodo_pkg::STEPS - 1)) state_r <= ST_C_END;
        end
        ST_C_END: begin
          if (!csel_r) begin
            si_r    <= flip_r ? -cy_r : cy_r;
            state_r <= i_small ? ST_K_I2 : ST_K_DIV;
          end else begin
            sp_r    <= flip_r ? -cy_r : cy_r;
            cp_r    <= flip_r ? -cx_r : cx_r;
            state_r <= ST_Y1;
          end
        end
        ST_K_I2: if (alu_rsp.done) begin
          i2_r    <= alu_rsp.res;
          state_r <= ST_K_I4;
        end
        ST_K_I4: if (alu_rsp.done) begin
          acc_r   <= alu_rsp.res;
          state_r <= ST_K_Q1;
        end
        ST_K_Q1: if (alu_rsp.done) begin
          k_r     <= twodo_pkg::ONE_Q30 - $signed(alu_rsp.q);
          state_r <= ST_K_Q2;
        end
        ST_K_Q2: if (alu_rsp.done) begin
          k_r     <= k_r + $signed(alu_rsp.q);
          state_r <= ST_H1;
        end
        ST_K_DIV: if (alu_rsp.done) begin
          k_r     <= alu_rsp.res;
          state_r <= ST_H1;
        end
        ST_H1: if (alu_rsp.done) begin
          h_r     <= alu_rsp.res;
          state_r <= ST_H2;
        end
        ST_H2: if (alu_rsp.done) begin
          h_r     <= h_r + h2x;
          state_r <= ST_H3;
        end
        ST_H3: if (alu_rsp.done) begin
          h2_r    <= alu_rsp.res;
          state_r <= ST_H4;
        end
        ST_H4: if (alu_rsp.done) begin
          h2_r    <= h2_r + h2x;
          state_r <= ST_P_MOD;
        end
        ST_Y1: if (alu_rsp.done) begin
          acc_r   <= 64'(pose_y_r) + alu_rsp.res;
          state_r <= ST_Y2;
        end
        ST_Y2: if (alu_rsp.done) begin
          pose_y_r <= twodo_pkg::sat48(acc_r - alu_rsp.res);
          state_r  <= ST_X1;
        end
        ST_X1: if (alu_rsp.done) begin
          acc_r   <= 64'(pose_x_r) + alu_rsp.res;
          state_r <= ST_X2;
        end
        ST_X2: if (alu_rsp.done) begin
          pose_x_r <= twodo_pkg::sat48(acc_r + alu_rsp.res);
          pose_h_r <= twodo_pkg::sat48(64'(pose_h_r) + 64'(a_r));
          last_l_r <= cur_l_r;
          last_r_r <= cur_r_r;
          last_b_r <= cur_b_r;
          state_r  <= ST_DEG_M;
        end
        ST_DEG_M: if (alu_rsp.done) begin
          acc_r   <= alu_rsp.res;
          state_r <= ST_DEG_D;
        end
        ST_DEG_D: if (alu_rsp.done) begin
          deg_r   <= a_new;
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.x_position      <= pose_x_r;
            out_data_r.y_position      <= pose_y_r;
            out_data_r.heading_radians <= pose_h_r;
            out_data_r.heading_degrees <= deg_r;
            out_valid_r                <= 1'b1;
            state_r                    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> issued_r) else $error("arith result without request");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !issued_r) else $error("arith request left open");

  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && !out_stall) |=> out_valid_r) else $error("pose item lost");

  a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_C_IT) |-> (cnt_r < 5'(twodo_pkg::STEPS)))
    else $error("cordic step count overrun");

endmodule

### rtl/twodo_alu.sv
// Bit-serial multiply and divide unit, one bit per cycle over 64 bits.
// Depends on twodo_pkg.
module twodo_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  twodo_pkg::alu_req_t req,
  output twodo_pkg::alu_rsp_t rsp
);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIN} alu_st_t;

  alu_st_t            st_r;
  twodo_pkg::alu_op_t op_r;
  logic               neg_r, sat_r;
  logic [5:0]         cnt_r;
  logic [63:0]        ud_r, rem_r, lo_r, q_r;

  logic [63:0]  un, ud;
  logic [127:0] wide;
  logic [64:0]  t, diff, sum;
  logic         ge;
  logic [97:0]  r98;
  logic [63:0]  qr;

  always_comb begin
    un   = twodo_pkg::umag(req.a);
    ud   = twodo_pkg::umag(req.b);
    wide = {64'b0, un} << req.e;
    t    = {rem_r, lo_r[63]};
    diff = t - {1'b0, ud_r};
    ge   = t >= {1'b0, ud_r};
    sum  = {1'b0, rem_r} + (lo_r[0] ? {1'b0, ud_r} : 65'd0);
    r98  = {rem_r, lo_r[63:30]} + {97'b0, lo_r[29]};
    qr   = q_r + {63'b0, (rem_r >= (ud_r - rem_r))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      unique case (st_r)
        A_IDLE: begin
          if (req.start) begin
            op_r  <= req.op;
            neg_r <= req.a[63] ^ req.b[63];
            cnt_r <= '0;
            if (req.op == twodo_pkg::OP_DIV) begin
              ud_r  <= ud;
              rem_r <= wide[127:64];
              lo_r  <= wide[63:0];
              q_r   <= '0;
              sat_r <= wide[127:64] >= ud;
              st_r  <= (wide[127:64] >= ud) ? A_FIN : A_RUN;
            end else begin
              ud_r  <= un;
              rem_r <= '0;
              lo_r  <= ud;
              sat_r <= 1'b0;
              st_r  <= A_RUN;
            end
          end
        end
        A_RUN: begin
          if (op_r == twodo_pkg::OP_DIV) begin
            rem_r <= ge ? diff[63:0] : t[63:0];
            lo_r  <= {lo_r[62:0], 1'b0};
            q_r   <= {q_r[62:0], ge};
          end else begin
            rem_r <= sum[64:1];
            lo_r  <= {sum[0], lo_r[63:1]};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) st_r <= A_FIN;
        end
        A_FIN: st_r <= A_IDLE;
        default: st_r <= A_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.done = (st_r == A_FIN);
    rsp.q    = q_r;
    rsp.rem  = rem_r;
    unique case (op_r)
      twodo_pkg::OP_DIV:
        rsp.res = sat_r ? twodo_pkg::from_mag(twodo_pkg::LIM_U, neg_r)
                        : twodo_pkg::from_mag(qr, neg_r);
      twodo_pkg::OP_MUL30:
        rsp.res = (r98[97:64] != 34'd0) ? twodo_pkg::from_mag(twodo_pkg::LIM_U, neg_r)
                                        : twodo_pkg::from_mag(r98[63:0], neg_r);
      twodo_pkg::OP_MUL_RAW:
        rsp.res = neg_r ? -$signed(lo_r) : $signed(lo_r);
      default: rsp.res = '0;
    endcase
  end

endmodule
